// ----- hw/rtl/aes_pkg.sv -----
// ============================================================================
// AES-128 package
// Shared types, constants and round functions for the AES-128 block pipeline.
// ============================================================================
package aes_pkg;

  localparam int unsigned BlockW    = 128;
  localparam int unsigned NumRounds = 10;

  // Register map: 64-bit registers at 8-byte strides, selected by paddr[3]
  typedef enum logic {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_t;

  // State plus the round key that goes with it; byte k sits at [127-8k -: 8]
  typedef struct packed {
    logic [BlockW-1:0] state;
    logic [BlockW-1:0] rkey;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  // Round constant for the key words of round rnd (1..10)
  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1B;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] mix_column(input logic [31:0] col);
    logic [7:0] a0, a1, a2, a3;
    a0 = col[31:24];
    a1 = col[23:16];
    a2 = col[15:8];
    a3 = col[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            xtime(a1) ^ xtime(a2) ^ a2 ^ a3 ^ a0,
            xtime(a2) ^ xtime(a3) ^ a3 ^ a0 ^ a1,
            xtime(a3) ^ xtime(a0) ^ a0 ^ a1 ^ a2};
  endfunction

  // SubBytes and ShiftRows: out byte (c,r) = S(in byte ((c+r) mod 4, r))
  function automatic logic [BlockW-1:0] sub_shift(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] t;
    logic [1:0]        src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = 2'(c + r);
        t[BlockW-1-8*(4*c+r) -: 8] = sbox(s[BlockW-1-8*(4*int'(src)+r) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [BlockW-1:0] mix_columns(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] t;
    for (int c = 0; c < 4; c++) begin
      t[BlockW-1-32*c -: 32] = mix_column(s[BlockW-1-32*c -: 32]);
    end
    return t;
  endfunction

  // One step of the key schedule: round key rnd-1 to round key rnd
  function automatic logic [BlockW-1:0] key_step(input logic [BlockW-1:0] k,
                                                 input logic [3:0]        rnd);
    logic [31:0] w0, w1, w2, w3, t;
    t  = k[31:0];
    t  = {sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])};
    t  = t ^ {rcon(rnd), 24'h000000};
    w0 = k[127:96] ^ t;
    w1 = k[95:64]  ^ w0;
    w2 = k[63:32]  ^ w1;
    w3 = k[31:0]   ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ----- hw/rtl/aes_cfg.sv -----
// ============================================================================
// AES key registers
// APB-style register file holding the 128-bit key as two 64-bit registers.
// ============================================================================
module aes_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output logic [127:0] key
);

  logic [63:0]       key_high_r;
  logic [63:0]       key_low_r;
  aes_pkg::reg_idx_t idx;
  logic              wr_en;

  // byte offset within a register is ignored
  assign idx    = aes_pkg::reg_idx_t'(paddr[3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        aes_pkg::REG_KEY_HIGH: key_high_r <= pwdata;
        aes_pkg::REG_KEY_LOW:  key_low_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      aes_pkg::REG_KEY_HIGH: prdata = key_high_r;
      aes_pkg::REG_KEY_LOW:  prdata = key_low_r;
      default:               prdata = '0;
    endcase
  end

  assign key = {key_high_r, key_low_r};

endmodule

// ----- hw/rtl/aes_round.sv -----
// ============================================================================
// AES round stage
// One registered cipher round with its key-schedule step; holds on stall.
// ============================================================================
module aes_round (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [3:0]      round_num,
  input  logic            valid_i,
  output logic            ready_o,
  input  aes_pkg::stage_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output aes_pkg::stage_t data_o
);

  logic                            valid_r;
  aes_pkg::stage_t                 data_r;
  aes_pkg::stage_t                 data_nxt;
  logic [aes_pkg::BlockW-1:0]      sub;
  logic                            last;

  assign last    = (round_num == 4'(aes_pkg::NumRounds));
  assign ready_o = !valid_r || ready_i;

  always_comb begin
    sub            = aes_pkg::sub_shift(data_i.state);
    data_nxt.rkey  = aes_pkg::key_step(data_i.rkey, round_num);
    data_nxt.state = (last ? sub : aes_pkg::mix_columns(sub)) ^ data_nxt.rkey;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ----- hw/rtl/aes128_block_encrypt_unit.sv -----
// Latency: 11 register stages (key add + 10 rounds). Throughput: one block per
// cycle while out_ready stays high; every stage is a valid/ready register stage.
// Each round stage runs one S-box/MixColumns layer plus its key-schedule step;
// the last round (10) skips MixColumns.
// Reset (rst_n low, synchronous) clears all stage valid bits and both key registers.
// ============================================================================
// AES-128 block encryption unit
// Fully unrolled AES-128 encryptor: initial key add stage, ten round stages,
// round keys carried through the pipeline next to each block.
// ============================================================================
module aes128_block_encrypt_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_plain_high,
  input  logic [63:0] in_plain_low,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_cipher_high,
  output logic [63:0] out_cipher_low,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned NumStages = aes_pkg::NumRounds + 1;

  logic [127:0]    key;
  // stage 0 is the initial AddRoundKey; stages 1..10 are the rounds
  logic            stg_valid [NumStages];
  logic            stg_ready [NumStages+1];
  aes_pkg::stage_t stg_data  [NumStages];

  logic            s0_valid_r;
  aes_pkg::stage_t s0_data_r;
  aes_pkg::stage_t s0_data_nxt;

  // transactions in flight, for checking only
  logic [3:0]      in_flight_r;
  logic [3:0]      in_flight_nxt;
  logic [NumStages-1:0] valid_vec;

  aes_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .key     (key)
  );

  // Stage 0: whiten with the cipher key, which also seeds the key pipeline.
  always_comb begin
    s0_data_nxt.rkey  = key;
    s0_data_nxt.state = {in_plain_high, in_plain_low} ^ key;
  end

  assign stg_ready[0] = !s0_valid_r || stg_ready[1];
  assign in_ready     = stg_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (stg_ready[0]) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_data_r <= s0_data_nxt;
    end
  end

  assign stg_valid[0] = s0_valid_r;
  assign stg_data[0]  = s0_data_r;

  // Rounds 1..10; the last one skips MixColumns.
  for (genvar i = 1; i < NumStages; i++) begin : g_round
    aes_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .round_num (4'(i)),
      .valid_i   (stg_valid[i-1]),
      .ready_o   (stg_ready[i]),
      .data_i    (stg_data[i-1]),
      .valid_o   (stg_valid[i]),
      .ready_i   (stg_ready[i+1]),
      .data_o    (stg_data[i])
    );
  end

  // The last round register is the output register.
  assign stg_ready[NumStages] = out_ready;
  assign out_valid            = stg_valid[NumStages-1];
  assign out_cipher_high      = stg_data[NumStages-1].state[127:64];
  assign out_cipher_low       = stg_data[NumStages-1].state[63:0];

  always_comb begin
    for (int k = 0; k < NumStages; k++) begin
      valid_vec[k] = stg_valid[k];
    end
    in_flight_nxt = in_flight_r + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_flight_r <= '0;
    end else begin
      in_flight_r <= in_flight_nxt;
    end
  end

  // No transaction is lost or duplicated inside the pipeline.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    in_flight_r == 4'($countones(valid_vec)))
    else $error("pipeline occupancy does not match transaction count");

  // Input backpressure only when every stage is occupied.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&valid_vec))
    else $error("input stalled with a free stage");

  // A stalled middle stage keeps its block and round key.
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid[5] && !stg_ready[6]) |=> (stg_valid[5] && $stable(stg_data[5])))
    else $error("stalled round stage changed");

  // A reset cycle leaves both key registers cleared.
  a_key_after_reset: assert property (@(posedge clk)
    !rst_n |=> (key == '0))
    else $error("key registers not cleared by reset");

endmodule

// ----- sim/tb_aes128_block_encrypt_unit.sv -----
// ============================================================================
// AES-128 block encrypt unit testbench
// Pushes plaintext blocks through the encrypt pipeline under several keys,
// predicts each ciphertext not typed in with an in-bench AES-128 model, compares
// every result field by field, in order, with random stalls on both sides.
// ============================================================================
module tb_aes128_block_encrypt_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Pipeline depth from the top-level notes: key add stage plus ten rounds
  localparam int LAT            = 11;
  localparam int HOLD_CYCLES    = 80;    // long receiver hold-off for backpressure
  localparam int NUM_PHASES     = 8;     // random phases, one key each
  localparam int PHASE_ITEMS    = 200;
  localparam int BURST_ITEMS    = 48;    // back-to-back blocks during the hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
  localparam int NUM_DIR        = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_plain_high;
  logic [63:0] in_plain_low;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_cipher_high;
  logic [63:0] out_cipher_low;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  aes128_block_encrypt_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_plain_high   (in_plain_high),
    .in_plain_low    (in_plain_low),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cipher_high (out_cipher_high),
    .out_cipher_low  (out_cipher_low),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  bit [7:0]   sbox_tbl [256];    // built at time zero from GF(2^8) inverses
  bit [127:0] key_q;             // bench copy of {key_high, key_low}
  bit [127:0] expected_cipher[$];
  int         mismatch_cnt;
  int         quiet_cycles;
  bit         idle_on;           // random gaps/stalls enabled on both sides
  bit         hold_req;          // asks the result side for one long hold-off

  // Directed vectors. Ciphertext is typed in only for the all-zero row and the
  // published FIPS-197 vectors; all other rows go through the predictor.
  typedef struct packed {
    logic [127:0] key;
    logic [127:0] plain;
    logic         known;
    logic [127:0] cipher;
  } vec_t;

  localparam logic [127:0] ONES  = {128{1'b1}};
  localparam logic [127:0] KEY_B = 128'h2b7e151628aed2a6abf7158809cf4f3c;
  localparam logic [127:0] KEY_C = 128'h000102030405060708090a0b0c0d0e0f;

  localparam vec_t DIR_TBL [NUM_DIR] = '{
    // reset key (all zero)
    '{128'h0, 128'h0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
    '{128'h0, ONES, 1'b0, 128'h0},
    '{128'h0, {64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, 1'b0, 128'h0},
    '{128'h0, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, 128'h0},
    '{128'h0, {1'b1, 127'h0}, 1'b0, 128'h0},   // byte 0 msb only
    '{128'h0, 128'h1, 1'b0, 128'h0},           // byte 15 lsb only
    '{128'h0, {16{8'h55}}, 1'b0, 128'h0},
    '{128'h0, {16{8'hAA}}, 1'b0, 128'h0},
    // FIPS-197 worked example and the AES-128 example vector
    '{KEY_B, 128'h3243f6a8885a308d313198a2e0370734, 1'b1,
      128'h3925841d02dc09fbdc118597196a0b32},
    '{KEY_C, 128'h00112233445566778899aabbccddeeff, 1'b1,
      128'h69c4e0d86a7b0430d8cdb78070b4c55a},
    '{KEY_C, 128'h0, 1'b0, 128'h0},
    // all-ones key
    '{ONES, 128'h0, 1'b0, 128'h0},
    '{ONES, ONES, 1'b0, 128'h0},
    '{ONES, 128'h0123456789abcdef_fedcba9876543210, 1'b0, 128'h0},
    // one register all ones, the other clear: catches swapped key halves
    '{{64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, 128'h1, 1'b0, 128'h0},
    '{{64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, ONES, 1'b0, 128'h0}
  };

  // --------------------------------------------------------------------------
  // AES-128 predictor
  // --------------------------------------------------------------------------
  function automatic bit [7:0] gf_dbl(input bit [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic bit [7:0] gf_mul(input bit [7:0] a, input bit [7:0] b);
    bit [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p = p ^ a;
      a = gf_dbl(a);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic bit [7:0] rotl8(input bit [7:0] x, input int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  // S-box = affine map of the multiplicative inverse (0 maps to 0)
  task automatic build_sbox();
    bit [7:0] inv;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++) begin
        if (gf_mul(8'(a), 8'(b)) == 8'h01) inv = 8'(b);
      end
      sbox_tbl[a] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4)
                    ^ 8'h63;
    end
  endtask

  // Byte k of a block is row k%4, column k/4; byte 0 is the top byte.
  function automatic bit [127:0] aes128_encrypt(input bit [127:0] key,
                                                input bit [127:0] blk);
    bit [31:0]  w [44];
    bit [7:0]   s [16];
    bit [7:0]   t [16];
    bit [31:0]  x;
    bit [7:0]   rc;
    bit [7:0]   a0, a1, a2, a3;
    bit [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      x = w[i-1];
      if (i % 4 == 0) begin
        x  = {x[23:0], x[31:24]};
        x  = {sbox_tbl[x[31:24]] ^ rc, sbox_tbl[x[23:16]], sbox_tbl[x[15:8]],
              sbox_tbl[x[7:0]]};
        rc = gf_dbl(rc);
      end
      w[i] = w[i-4] ^ x;
    end
    for (int k = 0; k < 16; k++) s[k] = blk[127-8*k -: 8];
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        // SubBytes + ShiftRows
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            t[4*c+r] = sbox_tbl[s[4*((c+r)%4)+r]];
        s = t;
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            s[4*c]   = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
            s[4*c+1] = gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3 ^ a0;
            s[4*c+2] = gf_dbl(a2) ^ gf_dbl(a3) ^ a3 ^ a0 ^ a1;
            s[4*c+3] = gf_dbl(a3) ^ gf_dbl(a0) ^ a0 ^ a1 ^ a2;
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          s[4*c+r] = s[4*c+r] ^ w[4*rnd+c][31-8*r -: 8];
    end
    for (int k = 0; k < 16; k++) res[127-8*k -: 8] = s[k];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_cnt++;
    $display("[%0t] ERROR %s: got %h want %h", $realtime, what, got, want);
  endtask

  // Each result transaction pops the oldest expected ciphertext.
  always @(posedge clk) begin : check_results
    bit [127:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_cipher.size() == 0) begin
        report_mismatch("result with nothing pending, cipher_high", out_cipher_high, 64'h0);
      end else begin
        want = expected_cipher.pop_front();
        if (out_cipher_high !== want[127:64])
          report_mismatch("cipher_high", out_cipher_high, want[127:64]);
        if (out_cipher_low !== want[63:0])
          report_mismatch("cipher_low", out_cipher_low, want[63:0]);
      end
    end
  end

  // Watchdog: any transaction on any port resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: per-transaction random stall, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        // keep ready low long enough for the pipeline to fill and push back
        @(negedge clk);
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 5) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // --------------------------------------------------------------------------
  // Input side and configuration
  // --------------------------------------------------------------------------

  // Offers one block after a gap; valid stays high across back-to-back blocks.
  task automatic send_block(input bit [127:0] plain, input bit known,
                            input bit [127:0] known_ct);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid      = 1'b1;
    in_plain_high = plain[127:64];
    in_plain_low  = plain[63:0];
    do @(posedge clk); while (!in_ready);
    // key is sampled with the block, so predict with the current key now
    expected_cipher.push_back(known ? known_ct : aes128_encrypt(key_q, plain));
  endtask

  // Sender pause: wait out every pending result, then the pipeline depth.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_cipher.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  // APB write (setup + access), then read back the same register.
  task automatic write_reg(input aes_pkg::reg_idx_t idx, input bit [63:0] val);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 3'b000};
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== val) report_mismatch("register readback", cfg_prdata, val);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Key changes only with the pipeline empty.
  task automatic load_key(input bit [127:0] key);
    drain_results();
    write_reg(aes_pkg::REG_KEY_HIGH, key[127:64]);
    write_reg(aes_pkg::REG_KEY_LOW, key[63:0]);
    key_q = key;
  endtask

  function automatic bit [127:0] rand_block();
    bit [127:0] b;
    case ($urandom_range(0, 15))
      0:       b = 128'h0;
      1:       b = ONES;
      2: begin
        b = 128'h0;
        b[8*$urandom_range(0, 15) +: 8] = 8'($urandom_range(1, 255));
      end
      default: b = {$urandom, $urandom, $urandom, $urandom};
    endcase
    return b;
  endfunction

  initial begin : stimulus
    bit [127:0] key;
    in_valid      = 1'b0;
    in_plain_high = '0;
    in_plain_low  = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    mismatch_cnt  = 0;
    quiet_cycles  = 0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    key_q         = '0;     // registers reset to zero
    build_sbox();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed vectors; first rows run on the reset key with no write
    for (int i = 0; i < NUM_DIR; i++) begin
      if (DIR_TBL[i].key != key_q) load_key(DIR_TBL[i].key);
      send_block(DIR_TBL[i].plain, DIR_TBL[i].known, DIR_TBL[i].cipher);
    end

    // Random phases: extreme keys first, then random ones
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       key = ONES;
        1:       key = 128'h0;
        default: key = {$urandom, $urandom, $urandom, $urandom};
      endcase
      load_key(key);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stretches of 50 transactions, about a quarter with no idling at all
        if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
        send_block(rand_block(), 1'b0, 128'h0);
      end

      // Backpressure burst: receiver holds off while blocks keep coming
      if (p == 3) begin
        drain_results();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        for (int n = 0; n < BURST_ITEMS; n++) send_block(rand_block(), 1'b0, 128'h0);
        drain_results();
        idle_on = 1'b1;
      end
    end

    drain_results();
    repeat (LAT) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/aes_pkg.sv
hw/rtl/aes_cfg.sv
hw/rtl/aes_round.sv
hw/rtl/aes128_block_encrypt_unit.sv
sim/tb_aes128_block_encrypt_unit.sv
